// ===== hdl/npcs_pkg.sv =====
// ----------------------------------------------------------------------------
// npcs_pkg
// Types and constants shared by the nearest palette colour search.
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

  // Width of one colour channel.
  localparam int unsigned CHAN_W = 8;

  // Width of a squared distance over three channels (max 3 * 255^2 = 195075).
  localparam int unsigned DIST_W = 18;

  // Width of the running best distance; wide enough to hold its start value.
  localparam int unsigned BEST_W = 24;

  // Start value of the running best, above any real distance.
  localparam logic [BEST_W-1:0] START_BEST = 24'hffffff;

  // Request codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_MATCH = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [2*CHAN_W-1:0] square_t;

  // One palette entry as held in the store.
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

endpackage

`default_nettype wire

// ===== hdl/nearest_palette_color_search.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette store with a nearest-colour search by squared Euclidean distance.
// ----------------------------------------------------------------------------
// A write request (action low) stores red, green and blue at entry_index;
// indexes at or beyond PALETTE_ENTRIES are dropped, and a write gives no
// result. A match request (action high) holds busy while the block reads
// entries 1 to PALETTE_ENTRIES-1 from the palette memory, one read per
// cycle, and returns the lowest-numbered entry at the smallest distance.
// For the default depth the scan makes 255 memory reads through the single
// read port of the palette memory, which then pass the read, square, sum
// and result stages. The result is shown on match_index and match_distance
// for exactly one cycle while done is high, and busy is already low in that
// cycle. There is no back-pressure: capture the result when done is high.
// Entry 0 is never a candidate. Read only entries that have been written;
// an unwritten entry holds unknown data. Palette contents are not cleared
// by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_search #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [7:0]  entry_index,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  output logic             done,
  output logic [7:0]       match_index,
  output logic [17:0]      match_distance
);

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

  // Palette memory: one write port, one registered read port.
  npcs_pkg::rgb_t palette_store [PALETTE_ENTRIES];

  logic                  accept;
  logic                  wr_en;
  logic                  match_go;

  // Query colour, held for the whole scan.
  npcs_pkg::chan_t       q_red;
  npcs_pkg::chan_t       q_green;
  npcs_pkg::chan_t       q_blue;

  // Scan address generator.
  logic                  scan_active;
  logic [IDX_W-1:0]      scan_addr;

  // Stage 1: registered memory read.
  logic                  s1_valid;
  logic                  s1_last;
  logic [IDX_W-1:0]      s1_idx;
  npcs_pkg::rgb_t        s1_data;

  // Stage 2: squared channel differences.
  logic                  s2_valid;
  logic                  s2_last;
  logic [IDX_W-1:0]      s2_idx;
  npcs_pkg::square_t     s2_sq_r;
  npcs_pkg::square_t     s2_sq_g;
  npcs_pkg::square_t     s2_sq_b;

  // Stage 3: summed distance.
  logic                  s3_valid;
  logic                  s3_last;
  logic [IDX_W-1:0]      s3_idx;
  logic [npcs_pkg::DIST_W-1:0] s3_dist;

  // Running minimum.
  logic [npcs_pkg::BEST_W-1:0] best;
  logic [IDX_W-1:0]            best_idx;
  logic [npcs_pkg::BEST_W-1:0] best_next;
  logic [IDX_W-1:0]            best_idx_next;

  npcs_pkg::chan_t       d_r;
  npcs_pkg::chan_t       d_g;
  npcs_pkg::chan_t       d_b;

  assign accept   = start && !busy;
  assign wr_en    = accept && (action == npcs_pkg::ACT_WRITE) &&
                    (32'(entry_index) < PALETTE_ENTRIES);
  assign match_go = accept && (action == npcs_pkg::ACT_MATCH);

  // Write on request; read the scan address while scanning.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_store[IDX_W'(entry_index)] <= '{red: red, green: green, blue: blue};
    end
    if (scan_active) begin
      s1_data <= palette_store[scan_addr];
    end
  end

  // Hold the query colour.
  always_ff @(posedge clk) begin
    if (match_go) begin
      q_red   <= red;
      q_green <= green;
      q_blue  <= blue;
    end
  end

  // Advance the scan from entry 1 to the last entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      scan_addr   <= FIRST_IDX;
    end else if (match_go) begin
      scan_active <= 1'b1;
      scan_addr   <= FIRST_IDX;
    end else if (scan_active) begin
      if (scan_addr == LAST_IDX) begin
        scan_active <= 1'b0;
      end else begin
        scan_addr <= scan_addr + FIRST_IDX;
      end
    end
  end

  // Absolute channel differences against the entry just read.
  always_comb begin
    d_r = (q_red   > s1_data.red)   ? q_red   - s1_data.red   : s1_data.red   - q_red;
    d_g = (q_green > s1_data.green) ? q_green - s1_data.green : s1_data.green - q_green;
    d_b = (q_blue  > s1_data.blue)  ? q_blue  - s1_data.blue  : s1_data.blue  - q_blue;
  end

  // Pipeline valid flags and tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= scan_active;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= scan_addr;
    s1_last <= (scan_addr == LAST_IDX);
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    s3_idx  <= s2_idx;
    s3_last <= s2_last;
    // One 8x8 square per channel, then the sum in the next stage.
    s2_sq_r <= npcs_pkg::square_t'(d_r) * npcs_pkg::square_t'(d_r);
    s2_sq_g <= npcs_pkg::square_t'(d_g) * npcs_pkg::square_t'(d_g);
    s2_sq_b <= npcs_pkg::square_t'(d_b) * npcs_pkg::square_t'(d_b);
    s3_dist <= npcs_pkg::DIST_W'(s2_sq_r) + npcs_pkg::DIST_W'(s2_sq_g) +
               npcs_pkg::DIST_W'(s2_sq_b);
  end

  // Strictly-less compare keeps the lowest index on a tie.
  always_comb begin
    best_next     = best;
    best_idx_next = best_idx;
    if (s3_valid && (npcs_pkg::BEST_W'(s3_dist) < best)) begin
      best_next     = npcs_pkg::BEST_W'(s3_dist);
      best_idx_next = s3_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best     <= npcs_pkg::START_BEST;
      best_idx <= '0;
    end else if (s3_valid && s3_last) begin
      // Re-arm for the next match request.
      best     <= npcs_pkg::START_BEST;
      best_idx <= '0;
    end else begin
      best     <= best_next;
      best_idx <= best_idx_next;
    end
  end

  // Deliver the result and release busy on the last candidate.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= s3_valid && s3_last;
      if (match_go) begin
        busy <= 1'b1;
      end else if (s3_valid && s3_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s3_last) begin
      match_index    <= 8'(best_idx_next);
      match_distance <= best_next[npcs_pkg::DIST_W-1:0];
    end
  end

  // A result only follows a match request that was in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result strobe without a match in progress");

  // Entry 0 is never read as a candidate.
  a_scan_skips_zero: assert property (@(posedge clk) disable iff (rst)
    scan_active |-> (scan_addr != '0))
    else $error("scan reached entry 0");

  // Scan and compare pipeline only run inside a match request.
  a_pipe_in_busy: assert property (@(posedge clk) disable iff (rst)
    (s1_valid || s2_valid || s3_valid || scan_active) |-> busy)
    else $error("scan pipeline active while idle");

endmodule

`default_nettype wire
